// ===== hdl/tqes_pkg.sv =====
`timescale 1ns / 1ps
package tqes_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int TIME_W    = 48;
  localparam int PER_W     = 31;
  localparam int SEQ_W     = 16;
  localparam int SLOT_W    = 4;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    K_ADDED    = 3'd0,
    K_FULL     = 3'd1,
    K_CANCELED = 3'd2,
    K_MISSED   = 3'd3,
    K_EXPIRED  = 3'd4,
    K_DONE     = 3'd5
  } kind_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [TIME_W-1:0] expire_at;
    logic [PER_W-1:0]  period;
    logic [SLOT_W-1:0] slot_id;
    logic [SEQ_W-1:0]  seq_tag;
    logic [TIME_W-1:0] current_time;
  } in_t;

  typedef struct packed {
    logic [2:0]        result_kind;
    logic [SLOT_W-1:0] event_slot;
    logic [SEQ_W-1:0]  event_seq;
    logic              head_changed;
    logic              next_valid;
    logic [TIME_W-1:0] next_due;
    logic              last_of_run;
  } out_t;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic [SLOT_W-1:0] sel;
    logic              add_en;
    logic              cancel_en;
    logic              rearm_en;
    logic              free_en;
    logic              arm_due;
    logic [TIME_W-1:0] new_exp;
    logic [PER_W-1:0]  new_per;
    logic [SEQ_W-1:0]  new_seq;
    logic [TIME_W-1:0] now;
  } cell_ctl_t;

  // Scan token that moves one cell per cycle along the chain.
  typedef struct packed {
    logic              v_any;
    logic [TIME_W-1:0] v_best;
    logic              d_any;
    logic [TIME_W-1:0] d_best;
    logic [SLOT_W-1:0] d_idx;
    logic [SEQ_W-1:0]  d_seq;
    logic [PER_W-1:0]  d_per;
    logic              f_any;
    logic [SLOT_W-1:0] f_idx;
  } tok_t;

endpackage

// ===== hdl/timer_queue_expiry_scheduler_top.sv =====
`timescale 1ns / 1ps
// Timer table of sixteen slots kept in a chain of cells.
// Input channel: in_valid_i / in_stall_o carry one command (add, cancel,
// tick) per transaction. Output channel: out_valid_o / out_stall_i carry
// result transactions; the final result of each command has last_of_run set.
// Command code 3 is dropped and gives no result.
// Every command runs a scan token down the chain of cells, one cell per
// cycle. An add or a cancel loads its single result at the end of its scan,
// and the next command can be accepted in the cycle after the load.
// A tick runs one scan per expired timer plus a final scan.
// One command is worked on at a time; in_stall_o is high until its last
// result has been loaded into the output register.
// A stalled output holds its result and the scan waits at its end.
// Reset empties the table and restarts sequence tags so the first add gets 1.
module timer_queue_expiry_scheduler_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tqes_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tqes_pkg::out_t out_data_o
);
  import tqes_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_SCAN} state_e;

  state_e            state_q, state_d;
  in_t               in_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SEQ_W-1:0]  ctr_q, ctr_d;
  logic              hit_q, hit_d;
  logic              ov_q, ov_d;
  out_t              out_q, res;
  logic              load;
  cell_ctl_t         ctl;
  tok_t              tok_init;
  tok_t              tok [NUM_SLOTS+1];
  logic [NUM_SLOTS-1:0] hits;
  tok_t              tk;
  logic              out_free, ec;
  logic [TIME_W:0]   sum;

  assign tok_init = '0;
  assign tok[0]   = tok_init;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    tqes_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (SLOT_W'(i)),
      .ctl_i  (ctl),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1]),
      .hit_o  (hits[i])
    );
  end

  assign tk       = tok[NUM_SLOTS];
  assign out_free = !ov_q || !out_stall_i;
  assign ec       = !tk.v_any || (in_q.expire_at < tk.v_best);
  assign sum      = {1'b0, in_q.current_time} + (TIME_W + 1)'(tk.d_per);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ctr_d   = ctr_q;
    hit_d   = hit_q;
    load    = 1'b0;
    res     = '0;
    ctl     = '0;
    ctl.now     = in_q.current_time;
    ctl.new_exp = in_q.expire_at;
    ctl.new_per = in_q.period;
    ctl.new_seq = in_q.seq_tag;
    ctl.sel     = in_q.slot_id;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && (in_data_i.cmd != CMD_NONE)) state_d = S_PREP;
      end
      S_PREP: begin
        if (in_q.cmd == CMD_CANCEL) begin
          hit_d         = |hits;
          ctl.cancel_en = |hits;
        end
        if (in_q.cmd == CMD_TICK) ctl.arm_due = 1'b1;
        cnt_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (cnt_q != CNT_W'(NUM_SLOTS)) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else if (out_free) begin
          load = 1'b1;
          res.next_valid  = tk.v_any;
          res.next_due    = tk.v_any ? tk.v_best : '0;
          res.last_of_run = 1'b1;
          state_d = S_IDLE;
          priority if (in_q.cmd == CMD_ADD) begin
            if (!tk.f_any) begin
              res.result_kind = K_FULL;
            end else begin
              res.result_kind  = K_ADDED;
              res.event_slot   = tk.f_idx;
              res.event_seq    = ctr_q + SEQ_W'(1);
              res.head_changed = ec;
              res.next_valid   = 1'b1;
              res.next_due     = ec ? in_q.expire_at : tk.v_best;
              ctl.sel     = tk.f_idx;
              ctl.add_en  = 1'b1;
              ctl.new_seq = ctr_q + SEQ_W'(1);
              ctr_d       = ctr_q + SEQ_W'(1);
            end
          end else if (in_q.cmd == CMD_CANCEL) begin
            res.result_kind = hit_q ? K_CANCELED : K_MISSED;
            res.event_slot  = in_q.slot_id;
            res.event_seq   = in_q.seq_tag;
          end else if (tk.d_any) begin
            res             = '0;
            res.result_kind = K_EXPIRED;
            res.event_slot  = tk.d_idx;
            res.event_seq   = tk.d_seq;
            ctl.sel         = tk.d_idx;
            if (tk.d_per != '0) begin
              ctl.rearm_en = 1'b1;
              ctl.new_exp  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            end else begin
              ctl.free_en = 1'b1;
            end
            cnt_d   = '0;
            state_d = S_SCAN;
          end else begin
            res.result_kind = K_DONE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    ov_d = ov_q;
    if (load) ov_d = 1'b1;
    else if (!out_stall_i) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ctr_q   <= '0;
      hit_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ctr_q   <= ctr_d;
      hit_q   <= hit_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) in_q <= in_data_i;
    if (load) out_q <= res;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/tqes_cell.sv =====
`timescale 1ns / 1ps
module tqes_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [tqes_pkg::SLOT_W-1:0] idx_i,
  input  tqes_pkg::cell_ctl_t       ctl_i,
  input  tqes_pkg::tok_t            tok_i,
  output tqes_pkg::tok_t            tok_o,
  output logic                      hit_o
);
  import tqes_pkg::*;

  logic              valid_q, due_q;
  logic [TIME_W-1:0] exp_q;
  logic [PER_W-1:0]  per_q;
  logic [SEQ_W-1:0]  seq_q;
  tok_t              tok_d, tok_q;
  logic              sel;

  assign sel   = (ctl_i.sel == idx_i);
  assign hit_o = valid_q && sel && (seq_q == ctl_i.new_seq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      due_q   <= 1'b0;
    end else begin
      if (ctl_i.add_en && sel) valid_q <= 1'b1;
      if (ctl_i.cancel_en && sel) valid_q <= 1'b0;
      if (ctl_i.free_en && sel) begin
        valid_q <= 1'b0;
        due_q   <= 1'b0;
      end
      if (ctl_i.rearm_en && sel) due_q <= 1'b0;
      if (ctl_i.arm_due) due_q <= valid_q && (exp_q <= ctl_i.now);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.add_en && sel) begin
      exp_q <= ctl_i.new_exp;
      per_q <= ctl_i.new_per;
      seq_q <= ctl_i.new_seq;
    end
    if (ctl_i.rearm_en && sel) exp_q <= ctl_i.new_exp;
  end

  // Fold this slot into the token. Strict compares keep the lower slot on ties.
  always_comb begin
    tok_d = tok_i;
    if (valid_q && (!tok_i.v_any || exp_q < tok_i.v_best)) begin
      tok_d.v_any  = 1'b1;
      tok_d.v_best = exp_q;
    end
    if (due_q && (!tok_i.d_any || exp_q < tok_i.d_best)) begin
      tok_d.d_any  = 1'b1;
      tok_d.d_best = exp_q;
      tok_d.d_idx  = idx_i;
      tok_d.d_seq  = seq_q;
      tok_d.d_per  = per_q;
    end
    if (!valid_q && !tok_i.f_any) begin
      tok_d.f_any = 1'b1;
      tok_d.f_idx = idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_o = tok_q;

endmodule

// ===== bench/timer_queue_expiry_scheduler_top_test.sv =====
`timescale 1ns / 1ps
module timer_queue_expiry_scheduler_top_test;
  import tqes_pkg::*;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam int CYCLE_LIMIT = 1500000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  timer_queue_expiry_scheduler_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  // Shadow copy of the timer table.
  logic              tbl_valid [NUM_SLOTS];
  logic [TIME_W-1:0] tbl_expiry [NUM_SLOTS];
  logic [PER_W-1:0]  tbl_period [NUM_SLOTS];
  logic [SEQ_W-1:0]  tbl_seq [NUM_SLOTS];
  logic [SEQ_W-1:0]  last_tag;

  out_t pending_results[$];
  int   mismatches;
  int   cycle_count;
  logic hold_off;

  function automatic logic table_earliest(output logic [TIME_W-1:0] when);
    logic any;
    any = 1'b0;
    when = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tbl_valid[i] && (!any || tbl_expiry[i] < when)) begin
        when = tbl_expiry[i];
        any = 1'b1;
      end
    end
    return any;
  endfunction

  function automatic out_t make_result(kind_e kind, logic [SLOT_W-1:0] slot,
                                       logic [SEQ_W-1:0] seq, logic ec, logic last);
    out_t r;
    logic [TIME_W-1:0] ne;
    logic nv;
    nv = table_earliest(ne);
    r.result_kind = kind;
    r.event_slot = slot;
    r.event_seq = seq;
    r.head_changed = ec;
    r.next_valid = last ? nv : 1'b0;
    r.next_due = last ? ne : '0;
    r.last_of_run = last;
    return r;
  endfunction

  // Applies one command to the shadow table and queues the results it causes.
  task automatic schedule_command(input in_t cmd_item);
    logic [TIME_W-1:0] prev;
    logic had;
    int free_slot;
    int pick;
    logic due [NUM_SLOTS];
    logic [TIME_W:0] sum;
    case (cmd_e'(cmd_item.cmd))
      CMD_ADD: begin
        had = table_earliest(prev);
        free_slot = -1;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) if (!tbl_valid[i]) free_slot = i;
        if (free_slot < 0) begin
          pending_results.push_back(make_result(K_FULL, '0, '0, 1'b0, 1'b1));
        end else begin
          last_tag = last_tag + 1'b1;
          tbl_valid[free_slot] = 1'b1;
          tbl_expiry[free_slot] = cmd_item.expire_at;
          tbl_period[free_slot] = cmd_item.period;
          tbl_seq[free_slot] = last_tag;
          pending_results.push_back(make_result(K_ADDED, SLOT_W'(free_slot), last_tag,
            !had || cmd_item.expire_at < prev, 1'b1));
        end
      end
      CMD_CANCEL: begin
        if (tbl_valid[cmd_item.slot_id] && tbl_seq[cmd_item.slot_id] == cmd_item.seq_tag) begin
          tbl_valid[cmd_item.slot_id] = 1'b0;
          pending_results.push_back(make_result(K_CANCELED, cmd_item.slot_id,
            cmd_item.seq_tag, 1'b0, 1'b1));
        end else begin
          pending_results.push_back(make_result(K_MISSED, cmd_item.slot_id,
            cmd_item.seq_tag, 1'b0, 1'b1));
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          due[i] = tbl_valid[i] && tbl_expiry[i] <= cmd_item.current_time;
        forever begin
          pick = -1;
          for (int i = 0; i < NUM_SLOTS; i++)
            if (due[i] && (pick < 0 || tbl_expiry[i] < tbl_expiry[pick])) pick = i;
          if (pick < 0) break;
          due[pick] = 1'b0;
          pending_results.push_back(make_result(K_EXPIRED, SLOT_W'(pick), tbl_seq[pick],
            1'b0, 1'b0));
          if (tbl_period[pick] != '0) begin
            sum = {1'b0, cmd_item.current_time} + (TIME_W + 1)'(tbl_period[pick]);
            tbl_expiry[pick] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
          end else begin
            tbl_valid[pick] = 1'b0;
          end
        end
        pending_results.push_back(make_result(K_DONE, '0, '0, 1'b0, 1'b1));
      end
      default: ;
    endcase
  endtask

  function automatic in_t make_cmd(cmd_e c, logic [TIME_W-1:0] t, logic [PER_W-1:0] p,
                                   logic [SLOT_W-1:0] s, logic [SEQ_W-1:0] g);
    in_t x;
    x.cmd = c;
    x.expire_at = t;
    x.period = p;
    x.slot_id = s;
    x.seq_tag = g;
    x.current_time = t;
    return x;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // Sends one command, waiting out a random gap first. Valid stays high
  // into the next command when the gap is zero.
  task automatic send_command(input in_t cmd_item);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= cmd_item;
    schedule_command(cmd_item);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Result checker: compares each accepted result with the oldest expectation.
  initial begin
    out_t exp_r;
    mismatches = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data_o);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_data_o !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %h, got %h", exp_r, out_data_o);
          end
        end
      end
    end
  end

  // Output stall: random per result, plus one long hold-off.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        out_stall_i <= 1'b0;
        wait (!hold_off);
      end else if (out_valid_o && !out_stall_i && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Directed rows; tags follow the add order after reset.
  in_t directed_rows [] = '{
    make_cmd(CMD_TICK, '0, '0, '0, '0),
    make_cmd(CMD_CANCEL, '0, '0, 4'd0, 16'd1),
    make_cmd(CMD_ADD, TIME_MAX, '0, '0, '0),
    make_cmd(CMD_ADD, '0, {PER_W{1'b1}}, '0, '0),
    make_cmd(CMD_ADD, 48'd100, 31'd50, '0, '0),
    make_cmd(CMD_ADD, 48'd100, '0, '0, '0),
    make_cmd(CMD_CANCEL, '0, '0, 4'd3, 16'hFFFF),
    make_cmd(CMD_CANCEL, '0, '0, 4'd15, 16'd1),
    make_cmd(CMD_NONE, TIME_MAX, {PER_W{1'b1}}, 4'hF, 16'hFFFF),
    make_cmd(CMD_TICK, 48'd100, '0, '0, '0),
    make_cmd(CMD_ADD, 48'd5, 31'd7, '0, '0),
    make_cmd(CMD_TICK, TIME_MAX - 48'd3, '0, '0, '0),
    make_cmd(CMD_CANCEL, '0, '0, 4'd0, 16'd1),
    make_cmd(CMD_TICK, TIME_MAX, '0, '0, '0)
  };

  initial begin
    in_t item;
    int pick;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    hold_off = 1'b0;
    last_tag = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_expiry[i] = '0;
      tbl_period[i] = '0;
      tbl_seq[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_command(directed_rows[i]);
    // Fill the table to overflow.
    for (int i = 0; i < NUM_SLOTS + 2; i++)
      send_command(make_cmd(CMD_ADD, rand_time(), PER_W'($urandom), '0, '0));
    wait_drained();
    send_command(make_cmd(CMD_TICK, TIME_MAX, '0, '0, '0));

    // Block the output while commands keep coming.
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++)
      send_command(make_cmd(CMD_ADD, 48'(i), '0, '0, '0));
    hold_off = 1'b0;
    wait_drained();

    for (int n = 0; n < 440; n++) begin
      pick = $urandom_range(0, 99);
      item = make_cmd(CMD_ADD, '0, '0, '0, '0);
      item.expire_at = 48'($urandom_range(0, 2000));
      if ($urandom_range(0, 9) == 0) item.expire_at = rand_time();
      item.period = ($urandom_range(0, 1) == 0) ? '0 : PER_W'($urandom_range(1, 500));
      if ($urandom_range(0, 15) == 0) item.period = PER_W'($urandom);
      item.slot_id = SLOT_W'($urandom);
      item.seq_tag = SEQ_W'($urandom);
      item.current_time = 48'(n * 5 + $urandom_range(0, 300));
      if ($urandom_range(0, 19) == 0) item.current_time = rand_time();
      if (pick < 40) begin
        item.cmd = CMD_ADD;
      end else if (pick < 65) begin
        item.cmd = CMD_CANCEL;
        // Mostly aim at the slot with its real tag.
        if ($urandom_range(0, 2) != 0) item.seq_tag = tbl_seq[item.slot_id];
      end else if (pick < 97) begin
        item.cmd = CMD_TICK;
      end else begin
        item.cmd = CMD_NONE;
      end
      send_command(item);
      if (n == 220) wait_drained();
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tqes_pkg.sv
hdl/tqes_cell.sv
hdl/timer_queue_expiry_scheduler_top.sv
bench/timer_queue_expiry_scheduler_top_test.sv
